### hdl/bphd_pkg.sv
`default_nettype none

package bphd_pkg;

  // Width of the per-button fields on the item ports
  localparam int unsigned BtnFieldW = 2;
  localparam int unsigned TimerW    = 16;

  // Register reset values
  localparam logic [TimerW-1:0] DebounceReset = 16'd10;
  localparam logic [TimerW-1:0] HoldReset     = 16'd500;

  // Configuration register indexes
  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_HOLD     = 1'b1;

  // Item commands
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Sampled level code
  localparam logic LEVEL_DOWN = 1'b0;

  // Per-button control for one item
  typedef struct packed {
    logic fire;   // item moves into the result register this cycle
    logic clear;  // item is a clear command
    logic level;  // sampled level of this button
    logic sel;    // this button is selected by the clear mask
  } btn_ctrl_t;

  // Per-button status after the item
  typedef struct packed {
    logic was_pressed;
    logic held;
  } btn_stat_t;

endpackage

`default_nettype wire

### hdl/bphd_button.sv
`default_nettype none

module bphd_button (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bphd_pkg::btn_ctrl_t          ctrl_i,
  input  logic [bphd_pkg::TimerW-1:0]  debounce_ticks_i,
  input  logic [bphd_pkg::TimerW-1:0]  hold_ticks_i,
  output bphd_pkg::btn_stat_t          stat_d_o
);
  import bphd_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_DOWN_DEB    = 4'd1,
    PH_TIMING      = 4'd2,
    PH_HELD        = 4'd3,
    PH_WAIT_UP     = 4'd4,
    PH_WAIT_UP_H   = 4'd5,
    PH_UP_DEB      = 4'd6,
    PH_UP_DEB_H    = 4'd7,
    PH_WAS_PRESSED = 4'd8
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic              timer_zero;
  logic [TimerW-1:0] timer_dec;

  assign timer_zero = (timer_q == '0);
  assign timer_dec  = timer_q - TimerW'(1);

  // Next phase and timer for the pending item
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    if (ctrl_i.clear) begin
      if (ctrl_i.sel) begin
        phase_d = (phase_q == PH_HELD) ? PH_WAIT_UP_H : PH_IDLE;
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (ctrl_i.level == LEVEL_DOWN) begin
            timer_d = debounce_ticks_i;
            phase_d = PH_DOWN_DEB;
          end
        end
        PH_DOWN_DEB: begin
          if (!timer_zero) begin
            timer_d = timer_dec;
          end else begin
            phase_d = PH_TIMING;
            timer_d = hold_ticks_i;
          end
        end
        PH_TIMING: begin
          if (ctrl_i.level == LEVEL_DOWN && !timer_zero) begin
            timer_d = timer_dec;
            if (timer_dec == '0) phase_d = PH_HELD;
          end else begin
            phase_d = PH_WAIT_UP;
          end
        end
        PH_WAIT_UP: begin
          if (ctrl_i.level != LEVEL_DOWN) begin
            timer_d = debounce_ticks_i;
            phase_d = PH_UP_DEB;
          end
        end
        PH_WAIT_UP_H: begin
          if (ctrl_i.level != LEVEL_DOWN) begin
            timer_d = debounce_ticks_i;
            phase_d = PH_UP_DEB_H;
          end
        end
        PH_UP_DEB: begin
          if (!timer_zero) timer_d = timer_dec;
          else             phase_d = PH_WAS_PRESSED;
        end
        PH_UP_DEB_H: begin
          if (!timer_zero) timer_d = timer_dec;
          else             phase_d = PH_IDLE;
        end
        // Latched phases hold until cleared
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // Status as seen after this item
  assign stat_d_o.was_pressed = (phase_d == PH_WAS_PRESSED);
  assign stat_d_o.held        = (phase_d == PH_HELD);

  // Advance state when the item transfers to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= DebounceReset;
    end else if (ctrl_i.fire) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
    end
  end

endmodule

`default_nettype wire

### hdl/button_press_hold_detector.sv
// A transfer on the input reaches the result port through the input register,
//   then the per-button state update into the result register.
// Throughput: one item per cycle unless the output stalls; the per-button phase
//   machines and timers all update in parallel between the two registers.
// Reset: all buttons idle, timers at ten, debounce_ticks 10, hold_ticks 500.
`default_nettype none

module button_press_hold_detector #(
  parameter int unsigned NUM_BUTTONS = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [bphd_pkg::TimerW-1:0]      cfg_data_i,
  // Item input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic [bphd_pkg::BtnFieldW-1:0]   button_levels_i,
  input  logic [bphd_pkg::BtnFieldW-1:0]   button_mask_i,
  // Result output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bphd_pkg::BtnFieldW-1:0]   was_pressed_o,
  output logic [bphd_pkg::BtnFieldW-1:0]   held_o,
  output logic [bphd_pkg::BtnFieldW-1:0]   active_o
);
  import bphd_pkg::*;

  logic [TimerW-1:0]    debounce_ticks_q, hold_ticks_q;
  logic                 in_valid_q;
  logic                 command_q;
  logic [BtnFieldW-1:0] levels_q, mask_q;
  logic                 out_valid_q;
  logic [BtnFieldW-1:0] was_pressed_q, held_q;
  logic [BtnFieldW-1:0] was_pressed_d, held_d;
  logic                 out_free;
  logic                 fire;
  logic                 in_xfer;
  btn_stat_t            stat_d [NUM_BUTTONS];

  // Handshake: result register frees when empty or taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= DebounceReset;
      hold_ticks_q     <= HoldReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE: debounce_ticks_q <= cfg_data_i;
        CFG_HOLD:     hold_ticks_q     <= cfg_data_i;
        default:      hold_ticks_q     <= hold_ticks_q;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      command_q <= command_i;
      levels_q  <= button_levels_i;
      mask_q    <= button_mask_i;
    end
  end

  // One phase machine per button; buttons beyond the field see down and no mask
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    btn_ctrl_t ctrl;

    assign ctrl.fire  = fire;
    assign ctrl.clear = (command_q == CMD_CLEAR);
    if (b < BtnFieldW) begin : g_field
      assign ctrl.level = levels_q[b];
      assign ctrl.sel   = mask_q[b];
    end else begin : g_extra
      assign ctrl.level = LEVEL_DOWN;
      assign ctrl.sel   = 1'b0;
    end

    bphd_button u_button (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .ctrl_i           (ctrl),
      .debounce_ticks_i (debounce_ticks_q),
      .hold_ticks_i     (hold_ticks_q),
      .stat_d_o         (stat_d[b])
    );
  end

  // Gather result bits; buttons beyond the field width are dropped
  for (genvar j = 0; j < BtnFieldW; j++) begin : g_res
    if (j < NUM_BUTTONS) begin : g_used
      assign was_pressed_d[j] = stat_d[j].was_pressed;
      assign held_d[j]        = stat_d[j].held;
    end else begin : g_unused
      assign was_pressed_d[j] = 1'b0;
      assign held_d[j]        = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      was_pressed_q <= was_pressed_d;
      held_q        <= held_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign was_pressed_o = was_pressed_q;
  assign held_o        = held_q;
  assign active_o      = was_pressed_q | held_q;

endmodule

`default_nettype wire
